// ===== hw/rtl/dna_4mer_profile_compare_defines.svh =====
// Assertion helpers for the 4-mer profile block.
// Both expect clk and rst_n in scope and stand quiet while reset is held.
`ifndef DNA_4MER_PROFILE_COMPARE_DEFINES_SVH
`define DNA_4MER_PROFILE_COMPARE_DEFINES_SVH

// Check that pre implies post in the same cycle
`define DNA4_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dna4 same-cycle check failed");

// Check that pre implies post in the next cycle
`define DNA4_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dna4 next-cycle check failed");

`endif

// ===== hw/rtl/dna4_pkg.sv =====
package dna4_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int COUNTER_BITS_DEF  = 16;

    // Field and result widths
    localparam int CODE_W  = 2;
    localparam int HIST_W  = 6;
    localparam int WORD_W  = 8;
    localparam int COUNT_W = 8;
    localparam int OUT_W   = 16;
    localparam int SCORE_W = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [OUT_W-1:0]   OUT_MAX   = 16'hFFFF;
    localparam logic [SCORE_W-1:0] SCORE_MAX = 17'h1FFFF;
    localparam logic [1:0]         SEEN_FULL = 2'd3;

    // Request and result codes
    localparam logic REQ_SYMBOL  = 1'b0;
    localparam logic REQ_COMPARE = 1'b1;
    localparam logic KIND_COUNT  = 1'b0;
    localparam logic KIND_SCORE  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_all;
        logic latch;
        logic wipe;
        logic cmp_rd;
        logic update;
        logic report;
    } dna4_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic addr_last;
        logic last_flag;
    } dna4_sts_t;

endpackage

// ===== hw/rtl/dna4_ctrl.sv =====
module dna4_ctrl
    import dna4_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      req_type,
    input  logic      first_symbol,
    input  dna4_sts_t sts,
    output dna4_cmd_t cmd,
    output logic      busy
);

    typedef enum logic [7:0] {
        ST_INIT    = 8'b0000_0001,
        ST_IDLE    = 8'b0000_0010,
        ST_WIPE    = 8'b0000_0100,
        ST_SYM_RD  = 8'b0000_1000,
        ST_SYM_WR  = 8'b0001_0000,
        ST_CMP     = 8'b0010_0000,
        ST_CMP_END = 8'b0100_0000,
        ST_REPORT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence the transaction and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clear_all = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (req_type == REQ_COMPARE)
                    begin
                        state_next = ST_CMP;
                    end
                    else if (first_symbol)
                    begin
                        state_next = ST_WIPE;
                    end
                    else
                    begin
                        state_next = ST_SYM_RD;
                    end
                end
            end
            ST_WIPE:
            begin
                cmd.wipe = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_SYM_RD;
                end
            end
            ST_SYM_RD:
            begin
                state_next = ST_SYM_WR;
            end
            ST_SYM_WR:
            begin
                cmd.update = 1'b1;
                state_next = sts.last_flag ? ST_REPORT : ST_IDLE;
            end
            ST_CMP:
            begin
                cmd.cmp_rd = 1'b1;
                if (sts.addr_last)
                begin
                    state_next = ST_CMP_END;
                end
            end
            ST_CMP_END:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Hold the state, start in the table clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hw/rtl/dna4_dp.sv =====
module dna4_dp
    import dna4_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dna4_cmd_t          cmd,
    output dna4_sts_t          sts,
    input  logic               req_type,
    input  logic               table_sel,
    input  logic [7:0]         symbol,
    input  logic               last_symbol,
    output logic               done,
    output logic               result_kind,
    output logic [OUT_W-1:0]   word_count,
    output logic [OUT_W-1:0]   overflow_count,
    output logic [SCORE_W-1:0] shared_score
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int SUM_W  = $clog2(TABLE_ENTRIES * 255 + 1);
    localparam int CW     = COUNTER_BITS;
    localparam int CLIP_W = (CW > OUT_W) ? CW : OUT_W;
    localparam int TOT_W  = ((CW > SUM_W) ? CW : SUM_W) + 1;

    // Latched transaction
    logic              req_reg;
    logic              sel_reg;
    logic [CODE_W-1:0] code_reg;
    logic              last_reg;

    // Per-table counters
    logic [CW-1:0]     ovf_reg  [2];
    logic [CW-1:0]     ovf_next [2];
    logic [CW-1:0]     win_reg  [2];
    logic [CW-1:0]     win_next [2];
    logic [HIST_W-1:0] hist_reg [2];
    logic [HIST_W-1:0] hist_next[2];
    logic [1:0]        seen_reg [2];
    logic [1:0]        seen_next[2];

    // Profile tables
    logic [COUNT_W-1:0] tbl0_mem [TABLE_ENTRIES];
    logic [COUNT_W-1:0] tbl1_mem [TABLE_ENTRIES];
    logic [COUNT_W-1:0] rd0_reg;
    logic [COUNT_W-1:0] rd1_reg;

    logic [ADDR_W-1:0] sweep_addr_reg;
    logic              acc_en_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic               done_reg;
    logic               kind_reg;
    logic [OUT_W-1:0]   wc_reg;
    logic [OUT_W-1:0]   oc_reg;
    logic [SCORE_W-1:0] score_reg;

    logic [WORD_W-1:0]  word;
    logic [ADDR_W-1:0]  word_idx;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W-1:0] cur_count;
    logic [COUNT_W-1:0] min_count;
    logic               sweeping;
    logic               upd_write;
    logic               we0;
    logic               we1;
    logic [CW-1:0]      min_ovf;
    logic [TOT_W-1:0]   total;
    logic [CLIP_W-1:0]  win_wide;
    logic [CLIP_W-1:0]  ovf_wide;

    // Latch the incoming transaction
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= req_type;
            sel_reg  <= table_sel;
            code_reg <= symbol[2:1];
            last_reg <= last_symbol;
        end
    end

    // Form the window word, oldest symbol on top
    assign word      = {hist_reg[sel_reg], code_reg};
    assign word_idx  = word[ADDR_W-1:0];
    assign cur_count = sel_reg ? rd1_reg : rd0_reg;
    assign sweeping  = cmd.clear_all | cmd.wipe;
    assign upd_write = cmd.update & (seen_reg[sel_reg] == SEEN_FULL)
                       & (cur_count != COUNT_MAX);

    // Steer the table ports
    assign rd_addr = cmd.cmp_rd ? sweep_addr_reg : word_idx;
    assign wr_addr = sweeping ? sweep_addr_reg : word_idx;
    assign wr_data = sweeping ? '0 : cur_count + 1'b1;
    assign we0     = cmd.clear_all | ((cmd.wipe | upd_write) & (sel_reg == 1'b0));
    assign we1     = cmd.clear_all | ((cmd.wipe | upd_write) & (sel_reg == 1'b1));

    // Table memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            tbl0_mem[wr_addr] <= wr_data;
        end
        rd0_reg <= tbl0_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            tbl1_mem[wr_addr] <= wr_data;
        end
        rd1_reg <= tbl1_mem[rd_addr];
    end

    // Advance the sweep address, drop back to zero between sweeps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
            acc_en_reg     <= 1'b0;
        end
        else
        begin
            acc_en_reg <= cmd.cmp_rd;
            if (sweeping | cmd.cmp_rd)
            begin
                sweep_addr_reg <= sweep_addr_reg + 1'b1;
            end
            else
            begin
                sweep_addr_reg <= '0;
            end
        end
    end

    assign sts.addr_last = &sweep_addr_reg;
    assign sts.last_flag = last_reg;

    // Accumulate the smaller count of each entry pair
    assign min_count = (rd0_reg < rd1_reg) ? rd0_reg : rd1_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            sum_reg <= '0;
        end
        else if (acc_en_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(min_count);
        end
    end

    // Update the selected table's counters
    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            ovf_next[t]  = ovf_reg[t];
            win_next[t]  = win_reg[t];
            hist_next[t] = hist_reg[t];
            seen_next[t] = seen_reg[t];
        end
        if (cmd.wipe)
        begin
            ovf_next[sel_reg]  = '0;
            win_next[sel_reg]  = '0;
            hist_next[sel_reg] = '0;
            seen_next[sel_reg] = '0;
        end
        else if (cmd.update)
        begin
            hist_next[sel_reg] = word[HIST_W-1:0];
            if (seen_reg[sel_reg] == SEEN_FULL)
            begin
                if ((cur_count == COUNT_MAX) && (ovf_reg[sel_reg] != {CW{1'b1}}))
                begin
                    ovf_next[sel_reg] = ovf_reg[sel_reg] + 1'b1;
                end
                if (win_reg[sel_reg] != {CW{1'b1}})
                begin
                    win_next[sel_reg] = win_reg[sel_reg] + 1'b1;
                end
            end
            else
            begin
                seen_next[sel_reg] = seen_reg[sel_reg] + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < 2; t++)
            begin
                ovf_reg[t]  <= '0;
                win_reg[t]  <= '0;
                hist_reg[t] <= '0;
                seen_reg[t] <= '0;
            end
        end
        else
        begin
            for (int t = 0; t < 2; t++)
            begin
                ovf_reg[t]  <= ovf_next[t];
                win_reg[t]  <= win_next[t];
                hist_reg[t] <= hist_next[t];
                seen_reg[t] <= seen_next[t];
            end
        end
    end

    // Form the score and the clipped counts
    assign min_ovf  = (ovf_reg[0] < ovf_reg[1]) ? ovf_reg[0] : ovf_reg[1];
    assign total    = TOT_W'(sum_reg) + TOT_W'(min_ovf);
    assign win_wide = CLIP_W'(win_reg[sel_reg]);
    assign ovf_wide = CLIP_W'(ovf_reg[sel_reg]);

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            if (req_reg == REQ_COMPARE)
            begin
                kind_reg  <= KIND_SCORE;
                wc_reg    <= '0;
                oc_reg    <= '0;
                score_reg <= (total > TOT_W'(SCORE_MAX)) ? SCORE_MAX
                                                         : total[SCORE_W-1:0];
            end
            else
            begin
                kind_reg  <= KIND_COUNT;
                wc_reg    <= (win_wide > CLIP_W'(OUT_MAX)) ? OUT_MAX
                                                           : win_wide[OUT_W-1:0];
                oc_reg    <= (ovf_wide > CLIP_W'(OUT_MAX)) ? OUT_MAX
                                                           : ovf_wide[OUT_W-1:0];
                score_reg <= '0;
            end
        end
    end

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.report;
        end
    end

    assign done           = done_reg;
    assign result_kind    = kind_reg;
    assign word_count     = wc_reg;
    assign overflow_count = oc_reg;
    assign shared_score   = score_reg;

endmodule

// ===== hw/rtl/dna_4mer_profile_compare.sv =====
// 4-mer profile builder and comparator for DNA text.
// Command port: a transaction is taken at a clock edge with start high and busy
// low. A symbol transaction feeds one nucleotide byte into table table_sel;
// first_symbol wipes that table first, last_symbol asks for a count result.
// A compare transaction scores the overlap of the two tables.
// Results: done is high for exactly one cycle with result_kind, word_count,
// overflow_count and shared_score valid; the receiver cannot stall it.
// Transaction steps, in controller state order:
//   plain symbol: table read (SYM_RD), then count write (SYM_WR), then idle
//   first symbol: a table wipe (WIPE) comes first, one entry a cycle
//   last symbol: a report state (REPORT) follows, then done is registered
//   compare: a read walk over both tables (CMP), a drain state (CMP_END)
//     and a report state (REPORT), then done is registered
// The table walks are set by the single write/read port of each table.
// Reset: counters clear at once, then a sweep zeroes both tables with busy high;
// transactions are taken once busy falls.
module dna_4mer_profile_compare
    import dna4_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNTER_BITS  = COUNTER_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               req_type,
    input  logic               table_sel,
    input  logic [7:0]         symbol,
    input  logic               first_symbol,
    input  logic               last_symbol,
    output logic               done,
    output logic               result_kind,
    output logic [OUT_W-1:0]   word_count,
    output logic [OUT_W-1:0]   overflow_count,
    output logic [SCORE_W-1:0] shared_score
);

`include "dna_4mer_profile_compare_defines.svh"

    dna4_cmd_t cmd;
    dna4_sts_t sts;

    // Sequence each transaction
    dna4_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .first_symbol (first_symbol),
        .sts          (sts),
        .cmd          (cmd),
        .busy         (busy)
    );

    // Hold tables, counters and results
    dna4_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .table_sel      (table_sel),
        .symbol         (symbol),
        .last_symbol    (last_symbol),
        .done           (done),
        .result_kind    (result_kind),
        .word_count     (word_count),
        .overflow_count (overflow_count),
        .shared_score   (shared_score)
    );

    // Check result framing against the transaction flow
    `DNA4_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `DNA4_ASSERT_IMP(a_done_after_work, done, $past(busy))
    `DNA4_ASSERT_NXT(a_done_single, done, !done)
    `DNA4_ASSERT_IMP(a_kind_fields, done && (result_kind == KIND_COUNT), shared_score == '0)

endmodule

// ===== verif/testbench.sv =====
module testbench
    import dna4_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Worst case: every item a compare after the longest sender gap, plus the
    // reset wipe, taken three times over
    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int CTR_W = COUNTER_BITS_DEF;
    localparam int N_WORDS = TABLE_ENTRIES_DEF;
    localparam logic [7:0] BASES [8] = '{8'h41, 8'h43, 8'h54, 8'h47,
                                         8'h61, 8'h63, 8'h74, 8'h67};

    typedef struct {
        logic       req_type;
        logic       table_sel;
        logic [7:0] symbol;
        logic       first_symbol;
        logic       last_symbol;
        int         idle_cycles;
    } dna_req_t;

    typedef struct {
        logic               kind;
        logic [OUT_W-1:0]   windows;
        logic [OUT_W-1:0]   overflow;
        logic [SCORE_W-1:0] score;
    } profile_report_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               req_type;
    logic               table_sel;
    logic [7:0]         symbol;
    logic               first_symbol;
    logic               last_symbol;
    logic               done;
    logic               result_kind;
    logic [OUT_W-1:0]   word_count;
    logic [OUT_W-1:0]   overflow_count;
    logic [SCORE_W-1:0] shared_score;

    // Mirror of the block's profile state
    logic [COUNT_W-1:0] word_tally [2][N_WORDS];
    logic [CTR_W-1:0]   lost_tally [2];
    logic [CTR_W-1:0]   window_tally [2];
    logic [HIST_W-1:0]  code_trail [2];
    logic [1:0]         fill_level [2];

    dna_req_t        req_backlog [$];
    profile_report_t profile_reports [$];
    dna_req_t        cur_req;
    int              idle_count;
    bit              calm;
    int              queued;
    int              items_taken;
    int              reports_seen;
    int              scores_seen;
    int              fault_count;
    int              cycles;
    logic [OUT_W-1:0] peak_overflow;

    dna_4mer_profile_compare uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .table_sel      (table_sel),
        .symbol         (symbol),
        .first_symbol   (first_symbol),
        .last_symbol    (last_symbol),
        .done           (done),
        .result_kind    (result_kind),
        .word_count     (word_count),
        .overflow_count (overflow_count),
        .shared_score   (shared_score)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Sender gap per transaction; calm stretches carry no gaps at all
    function automatic int draw_idle();
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [7:0] nucleotide_byte();
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        return BASES[$urandom_range(0, 7)];
    endfunction

    task automatic queue_symbol(input logic tsel, input logic [7:0] sym,
                                input logic first, input logic last);
        dna_req_t r;
        r.req_type     = REQ_SYMBOL;
        r.table_sel    = tsel;
        r.symbol       = sym;
        r.first_symbol = first;
        r.last_symbol  = last;
        r.idle_cycles  = draw_idle();
        req_backlog.push_back(r);
        queued++;
    endtask

    // Side fields of a compare carry random junk: the block must ignore them
    task automatic queue_compare();
        dna_req_t r;
        r.req_type     = REQ_COMPARE;
        r.table_sel    = 1'($urandom_range(0, 1));
        r.symbol       = 8'($urandom_range(0, 255));
        r.first_symbol = 1'($urandom_range(0, 1));
        r.last_symbol  = 1'($urandom_range(0, 1));
        r.idle_cycles  = draw_idle();
        req_backlog.push_back(r);
        queued++;
    endtask

    // Advance the profile state by one transaction and queue any report it causes
    task automatic profile_update(input dna_req_t r);
        profile_report_t  rep;
        int unsigned      acc;
        logic [CTR_W-1:0] lo;
        logic [1:0]       code;
        logic [WORD_W-1:0] word;
        int               t;
        if (r.req_type == REQ_COMPARE)
        begin
            acc = 0;
            for (int i = 0; i < N_WORDS; i++)
                acc += (word_tally[0][i] < word_tally[1][i]) ?
                       word_tally[0][i] : word_tally[1][i];
            lo = (lost_tally[0] < lost_tally[1]) ? lost_tally[0] : lost_tally[1];
            acc += lo;
            rep.kind     = KIND_SCORE;
            rep.windows  = '0;
            rep.overflow = '0;
            rep.score    = (acc > SCORE_MAX) ? SCORE_MAX : SCORE_W'(acc);
            profile_reports.push_back(rep);
            scores_seen++;
            return;
        end
        t = r.table_sel;
        if (r.first_symbol)
        begin
            for (int i = 0; i < N_WORDS; i++)
                word_tally[t][i] = '0;
            lost_tally[t]   = '0;
            window_tally[t] = '0;
            code_trail[t]   = '0;
            fill_level[t]   = '0;
        end
        code = r.symbol[2:1];
        word = {code_trail[t], code};
        if (fill_level[t] == SEEN_FULL)
        begin
            if (word_tally[t][word] != COUNT_MAX)
                word_tally[t][word]++;
            else if (lost_tally[t] != '1)
                lost_tally[t]++;
            if (window_tally[t] != '1)
                window_tally[t]++;
        end
        else
            fill_level[t]++;
        code_trail[t] = word[HIST_W-1:0];
        if (r.last_symbol)
        begin
            rep.kind     = KIND_COUNT;
            rep.windows  = (window_tally[t] > OUT_MAX) ? OUT_MAX : OUT_W'(window_tally[t]);
            rep.overflow = (lost_tally[t] > OUT_MAX) ? OUT_MAX : OUT_W'(lost_tally[t]);
            rep.score    = '0;
            if (rep.overflow > peak_overflow)
                peak_overflow = rep.overflow;
            profile_reports.push_back(rep);
        end
    endtask

    task automatic present_request(input dna_req_t r);
        cur_req      <= r;
        start        <= 1'b1;
        req_type     <= r.req_type;
        table_sel    <= r.table_sel;
        symbol       <= r.symbol;
        first_symbol <= r.first_symbol;
        last_symbol  <= r.last_symbol;
    endtask

    // Driver: hold each transaction until taken, then wait out the next item's gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start        <= 1'b0;
            req_type     <= REQ_SYMBOL;
            table_sel    <= 1'b0;
            symbol       <= '0;
            first_symbol <= 1'b0;
            last_symbol  <= 1'b0;
            idle_count   <= 0;
        end
        else if (start && !busy)
        begin
            profile_update(cur_req);
            items_taken++;
            idle_count <= 0;
            if (req_backlog.size() > 0 && req_backlog[0].idle_cycles == 0)
                present_request(req_backlog.pop_front());
            else
                start <= 1'b0;
        end
        else if (!start && req_backlog.size() > 0)
        begin
            if (idle_count >= req_backlog[0].idle_cycles)
            begin
                present_request(req_backlog.pop_front());
                idle_count <= 0;
            end
            else
                idle_count <= idle_count + 1;
        end
    end

    // Monitor: check each strobed result against the oldest outstanding report
    // (fields printed as kind/windows/overflow/score)
    always @(posedge clk)
    begin
        profile_report_t want;
        if (rst_n && done)
        begin
            reports_seen++;
            if (profile_reports.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: %0d/%0d/%0d/%0d",
                             result_kind, word_count, overflow_count, shared_score);
            end
            else
            begin
                want = profile_reports.pop_front();
                if (result_kind !== want.kind || word_count !== want.windows ||
                    overflow_count !== want.overflow || shared_score !== want.score)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.kind, want.windows, want.overflow, want.score,
                                 result_kind, word_count, overflow_count, shared_score);
                end
            end
        end
    end

    // Guard against a hung block
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, profile_reports.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int   pick;
        int   len;
        int   tbl;
        bit   open;
        bit   close;
        bit   long_done;
        logic [1:0] code;
        logic [7:0] b;

        rst_n = 1'b0;
        calm = 1'b0;
        queued = 0;
        items_taken = 0;
        reports_seen = 0;
        scores_seen = 0;
        fault_count = 0;
        cycles = 0;
        peak_overflow = '0;
        long_done = 1'b0;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < N_WORDS; i++)
                word_tally[s][i] = '0;
            lost_tally[s]   = '0;
            window_tally[s] = '0;
            code_trail[s]   = '0;
            fill_level[s]   = '0;
        end

        // Directed: zero byte without a first flag straight after reset
        queue_symbol(1'b0, 8'h00, 1'b0, 1'b0);
        queue_compare();
        // Single-symbol sequence with first and last together
        queue_symbol(1'b1, 8'hFF, 1'b1, 1'b1);
        // Continue table 0 without a first flag, then carry on past its last
        queue_symbol(1'b0, 8'h41, 1'b0, 1'b0);
        queue_symbol(1'b0, 8'h43, 1'b0, 1'b0);
        queue_symbol(1'b0, 8'h47, 1'b0, 1'b0);
        queue_symbol(1'b0, 8'h54, 1'b0, 1'b1);
        queue_symbol(1'b0, 8'h47, 1'b0, 1'b1);
        queue_symbol(1'b1, 8'h47, 1'b1, 1'b0);
        queue_symbol(1'b1, 8'h47, 1'b0, 1'b0);
        queue_symbol(1'b1, 8'h54, 1'b0, 1'b0);
        queue_symbol(1'b1, 8'h41, 1'b0, 1'b0);
        queue_symbol(1'b1, 8'h63, 1'b0, 1'b1);
        queue_compare();
        // Extreme bytes in a fresh table 0
        queue_symbol(1'b0, 8'hFF, 1'b1, 1'b0);
        queue_symbol(1'b0, 8'h00, 1'b0, 1'b0);
        queue_symbol(1'b0, 8'hAA, 1'b0, 1'b0);
        queue_symbol(1'b0, 8'h55, 1'b0, 1'b1);
        queue_compare();
        queue_symbol(1'b1, 8'h41, 1'b1, 1'b1);
        queue_symbol(1'b1, 8'h41, 1'b0, 1'b0);
        queue_symbol(1'b1, 8'h41, 1'b0, 1'b0);
        queue_symbol(1'b1, 8'h41, 1'b0, 1'b1);
        queue_compare();

        // Random: mostly well-formed sequences, some compares and stray symbols
        while (queued < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (!long_done && queued >= 450)
            begin
                // Homopolymer runs push one word past 255 in both tables
                for (int s = 0; s < 2; s++)
                begin
                    code = 2'($urandom_range(0, 3));
                    len = $urandom_range(262, 300);
                    for (int k = 0; k < len; k++)
                    begin
                        b = 8'($urandom_range(0, 255));
                        b[2:1] = code;
                        queue_symbol(1'(s), b, k == 0, k == len - 1);
                    end
                end
                queue_compare();
                long_done = 1'b1;
            end
            else if (pick < 10)
                queue_compare();
            else if (pick < 16)
                queue_symbol(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
            begin
                tbl = $urandom_range(0, 1);
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) :
                      $urandom_range(1, 16);
                open = $urandom_range(0, 9) != 0;
                close = $urandom_range(0, 9) != 0;
                for (int k = 0; k < len; k++)
                    queue_symbol(1'(tbl), nucleotide_byte(),
                                 (k == 0 && open) || $urandom_range(0, 49) == 0,
                                 k == len - 1 && close);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: wait for every transaction to be taken and every report to arrive
        while (req_backlog.size() != 0 || start || profile_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions, %0d results checked (%0d scores)",
                 items_taken, reports_seen, scores_seen);
        $display("largest overflow count reported: %0d", peak_overflow);
        if (fault_count == 0)
            $display("PASS");
        else
        begin
            $display("%0d mismatches", fault_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
